// ===== src/psp_pkg.sv =====
// Shared types, constants and helpers for the payoff saddle point finder.
// No dependencies; every other file in src refers to it by scoped names.
package psp_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int DATA_W   = 16;
    localparam int CNT_W    = 5;
    localparam int POS_W    = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic lt;
        logic gt;
        logic eq;
    } t_cmp;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] limit);
        logic [CNT_W-1:0] c;
        c = v;
        if (c == '0) c = CNT_W'(1);
        if (c > limit) c = limit;
        return c;
    endfunction

endpackage

// ===== src/psp_if.sv =====
// Valid/ready channel interfaces for payoff entries and saddle point results.
// Depends on psp_pkg for field widths.
interface psp_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [psp_pkg::DATA_W-1:0]  payoff;

    modport source (output valid, output payoff, input ready);
    modport sink   (input valid, input payoff, output ready);
endinterface

interface psp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               has_saddle;
    logic [psp_pkg::CNT_W-1:0]          saddle_row;
    logic [psp_pkg::CNT_W-1:0]          saddle_col;
    logic signed [psp_pkg::DATA_W-1:0]  max_of_row_minima;
    logic signed [psp_pkg::DATA_W-1:0]  min_of_col_maxima;

    modport source (output valid, output has_saddle, output saddle_row, output saddle_col,
                    output max_of_row_minima, output min_of_col_maxima, input ready);
    modport sink   (input valid, input has_saddle, input saddle_row, input saddle_col,
                    input max_of_row_minima, input min_of_col_maxima, output ready);
endinterface

// ===== src/psp_cfg.sv =====
// APB register file holding the row and column counts of the matrix.
// Depends on psp_pkg; emits the effective counts and a restart strobe.
module psp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psp_pkg::APB_AW-1:0]   paddr,
    input  logic [psp_pkg::APB_DW-1:0]   pwdata,
    output logic [psp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output psp_pkg::t_cfg                o_cfg
);

    logic [psp_pkg::CNT_W-1:0] r_row_count;
    logic [psp_pkg::CNT_W-1:0] r_col_count;
    logic                      w_wr;
    psp_pkg::t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = psp_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= psp_pkg::CNT_W'(2);
            r_col_count <= psp_pkg::CNT_W'(2);
        end else if (w_wr) begin
            case (w_idx)
                psp_pkg::REG_ROW_COUNT: r_row_count <= pwdata[psp_pkg::CNT_W-1:0];
                psp_pkg::REG_COL_COUNT: r_col_count <= pwdata[psp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            psp_pkg::REG_ROW_COUNT:
                prdata = {{(psp_pkg::APB_DW-psp_pkg::CNT_W){1'b0}}, r_row_count};
            psp_pkg::REG_COL_COUNT:
                prdata = {{(psp_pkg::APB_DW-psp_pkg::CNT_W){1'b0}}, r_col_count};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.rows    = psp_pkg::eff_count(r_row_count, psp_pkg::CNT_W'(psp_pkg::MAX_ROWS));
    assign o_cfg.cols    = psp_pkg::eff_count(r_col_count, psp_pkg::CNT_W'(psp_pkg::MAX_COLS));
    assign o_cfg.restart = w_wr;

endmodule

// ===== src/psp_cmp.sv =====
// Shared signed compare unit used for every min, max and match step.
// Depends on psp_pkg for the data width and the result struct.
module psp_cmp (
    input  logic signed [psp_pkg::DATA_W-1:0] i_a,
    input  logic signed [psp_pkg::DATA_W-1:0] i_b,
    output psp_pkg::t_cmp                     o_res
);

    assign o_res.lt = i_a < i_b;
    assign o_res.gt = i_a > i_b;
    assign o_res.eq = i_a == i_b;

endmodule

// ===== src/psp_seq.sv =====
// Sequencer with the row minimum and column maximum stores.
// Depends on psp_pkg, psp_if and the shared compare unit driven through i_cmp/o_a/o_b.
module psp_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psp_pkg::t_cfg                     i_cfg,
    psp_in_if.sink                            i_in,
    psp_out_if.source                         o_out,
    output logic signed [psp_pkg::DATA_W-1:0] o_a,
    output logic signed [psp_pkg::DATA_W-1:0] o_b,
    input  psp_pkg::t_cmp                     i_cmp
);

    typedef enum logic [3:0] {
        S_IDLE, S_UROW, S_UCOL,
        S_RMX_RD, S_RMX_EV, S_CMN_RD, S_CMN_EV, S_CHK,
        S_FR_RD, S_FR_EV, S_FC_RD, S_FC_EV, S_DONE
    } t_state;

    t_state r_state;

    logic signed [psp_pkg::DATA_W-1:0] r_row_mem [psp_pkg::MAX_ROWS];
    logic signed [psp_pkg::DATA_W-1:0] r_col_mem [psp_pkg::MAX_COLS];
    logic signed [psp_pkg::DATA_W-1:0] r_rd_row;
    logic signed [psp_pkg::DATA_W-1:0] r_rd_col;

    logic [psp_pkg::POS_W-1:0] r_row_pos, r_col_pos;
    logic [psp_pkg::POS_W-1:0] r_row_cur, r_col_cur;
    logic [psp_pkg::POS_W-1:0] r_idx;
    logic signed [psp_pkg::DATA_W-1:0] r_pay;
    logic signed [psp_pkg::DATA_W-1:0] r_maxmin, r_minmax;
    logic                      r_saddle;
    logic [psp_pkg::CNT_W-1:0] r_srow, r_scol;

    logic                              r_ovalid;
    logic                              r_o_has;
    logic [psp_pkg::CNT_W-1:0]         r_o_row, r_o_col;
    logic signed [psp_pkg::DATA_W-1:0] r_o_mxmn, r_o_mnmx;

    logic                      w_accept;
    logic [psp_pkg::POS_W-1:0] w_row, w_col;
    logic [psp_pkg::POS_W-1:0] w_row_addr, w_col_addr;
    logic                      w_row_rd, w_col_rd, w_row_wr, w_col_wr;
    logic                      w_row_last, w_col_last, w_idx_last_r, w_idx_last_c;
    logic [psp_pkg::CNT_W-1:0] w_idx_inc;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_row = ({1'b0, r_row_pos} >= i_cfg.rows) ? '0 : r_row_pos;
    assign w_col = ({1'b0, r_col_pos} >= i_cfg.cols) ? '0 : r_col_pos;

    assign w_row_last   = ({1'b0, r_row_cur} + psp_pkg::CNT_W'(1)) >= i_cfg.rows;
    assign w_col_last   = ({1'b0, r_col_cur} + psp_pkg::CNT_W'(1)) >= i_cfg.cols;
    assign w_idx_inc    = {1'b0, r_idx} + psp_pkg::CNT_W'(1);
    assign w_idx_last_r = w_idx_inc >= i_cfg.rows;
    assign w_idx_last_c = w_idx_inc >= i_cfg.cols;

    assign w_row_addr = (r_state == S_IDLE) ? w_row : r_idx;
    assign w_col_addr = (r_state == S_IDLE) ? w_col : r_idx;
    assign w_row_rd   = w_accept || (r_state == S_RMX_RD) || (r_state == S_FR_RD);
    assign w_col_rd   = w_accept || (r_state == S_CMN_RD) || (r_state == S_FC_RD);
    assign w_row_wr   = (r_state == S_UROW) && ((r_col_cur == '0) || i_cmp.lt);
    assign w_col_wr   = (r_state == S_UCOL) && ((r_row_cur == '0) || i_cmp.gt);

    always_comb begin
        case (r_state)
            S_UROW:   begin o_a = r_pay;    o_b = r_rd_row; end
            S_UCOL:   begin o_a = r_pay;    o_b = r_rd_col; end
            S_RMX_EV: begin o_a = r_rd_row; o_b = r_maxmin; end
            S_CMN_EV: begin o_a = r_rd_col; o_b = r_minmax; end
            S_CHK:    begin o_a = r_maxmin; o_b = r_minmax; end
            S_FR_EV:  begin o_a = r_rd_row; o_b = r_minmax; end
            S_FC_EV:  begin o_a = r_rd_col; o_b = r_minmax; end
            default:  begin o_a = r_pay;    o_b = r_minmax; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_row_wr) r_row_mem[r_row_cur] <= r_pay;
        if (w_row_rd) r_rd_row <= r_row_mem[w_row_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_col_wr) r_col_mem[r_col_cur] <= r_pay;
        if (w_col_rd) r_rd_col <= r_col_mem[w_col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else begin
            if (r_ovalid && o_out.ready && (r_state != S_DONE)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_pay     <= i_in.payoff;
                        r_row_cur <= w_row;
                        r_col_cur <= w_col;
                        r_state   <= S_UROW;
                    end
                end
                S_UROW: r_state <= S_UCOL;
                S_UCOL: begin
                    if (w_col_last) begin
                        r_col_pos <= '0;
                        if (w_row_last) begin
                            r_row_pos <= '0;
                            r_idx     <= '0;
                            r_state   <= S_RMX_RD;
                        end else begin
                            r_row_pos <= r_row_cur + psp_pkg::POS_W'(1);
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        r_row_pos <= r_row_cur;
                        r_col_pos <= r_col_cur + psp_pkg::POS_W'(1);
                        r_state   <= S_IDLE;
                    end
                end
                S_RMX_RD: r_state <= S_RMX_EV;
                S_RMX_EV: begin
                    if ((r_idx == '0) || i_cmp.gt) r_maxmin <= r_rd_row;
                    if (w_idx_last_r) begin
                        r_idx   <= '0;
                        r_state <= S_CMN_RD;
                    end else begin
                        r_idx   <= w_idx_inc[psp_pkg::POS_W-1:0];
                        r_state <= S_RMX_RD;
                    end
                end
                S_CMN_RD: r_state <= S_CMN_EV;
                S_CMN_EV: begin
                    if ((r_idx == '0) || i_cmp.lt) r_minmax <= r_rd_col;
                    if (w_idx_last_c) begin
                        r_idx   <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_idx   <= w_idx_inc[psp_pkg::POS_W-1:0];
                        r_state <= S_CMN_RD;
                    end
                end
                S_CHK: begin
                    r_saddle <= i_cmp.eq;
                    r_srow   <= '0;
                    r_scol   <= '0;
                    r_idx    <= '0;
                    r_state  <= i_cmp.eq ? S_FR_RD : S_DONE;
                end
                S_FR_RD: r_state <= S_FR_EV;
                S_FR_EV: begin
                    if (i_cmp.eq) r_srow <= w_idx_inc;
                    if (i_cmp.eq || w_idx_last_r) begin
                        r_idx   <= '0;
                        r_state <= S_FC_RD;
                    end else begin
                        r_idx   <= w_idx_inc[psp_pkg::POS_W-1:0];
                        r_state <= S_FR_RD;
                    end
                end
                S_FC_RD: r_state <= S_FC_EV;
                S_FC_EV: begin
                    if (i_cmp.eq) r_scol <= w_idx_inc;
                    if (i_cmp.eq || w_idx_last_c) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= w_idx_inc[psp_pkg::POS_W-1:0];
                        r_state <= S_FC_RD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_has  <= r_saddle;
                        r_o_row  <= r_srow;
                        r_o_col  <= r_scol;
                        r_o_mxmn <= r_maxmin;
                        r_o_mnmx <= r_minmax;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg.restart) begin
                r_row_pos <= '0;
                r_col_pos <= '0;
            end
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.has_saddle        = r_o_has;
    assign o_out.saddle_row        = r_o_row;
    assign o_out.saddle_col        = r_o_col;
    assign o_out.max_of_row_minima = r_o_mxmn;
    assign o_out.min_of_col_maxima = r_o_mnmx;

    a_accept_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_UROW))
        else $error("accepted word did not start an update");

    a_saddle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_saddle) |->
            (o_out.saddle_row != '0) && (o_out.saddle_col != '0) &&
            (o_out.max_of_row_minima == o_out.min_of_col_maxima))
        else $error("saddle result with inconsistent fields");

    a_no_saddle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_saddle) |->
            (o_out.saddle_row == '0) && (o_out.saddle_col == '0) &&
            (o_out.max_of_row_minima != o_out.min_of_col_maxima))
        else $error("non-saddle result with inconsistent fields");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            ({1'b0, r_row_pos} < i_cfg.rows) && ({1'b0, r_col_pos} < i_cfg.cols))
        else $error("matrix position beyond configured size");

endmodule

// ===== src/payoff_saddle_point_finder_unit.sv =====
// Payoff saddle point finder: takes a zero-sum game payoff matrix, one signed
// 16-bit entry per word in row-wise order, and returns one result word per matrix.
// Configuration: APB registers row_count at 0x0 and col_count at 0x4 (1..16;
// 0 acts as 1, larger values saturate to 16). Any write restarts the matrix.
// Input channel i_in: ready only while the sequencer is idle; each entry passes
// through accept, row minimum update and column maximum update, using the
// shared compare unit and the single-port row and column stores.
// After the last entry the sequencer scans the row store for maxmin, then the
// column store for minmax, and checks the two for equality. If they match, it
// scans again to locate the first saddle row and column, then loads the result.
// Output channel o_out: the result sits in an output register until taken; the
// next matrix is accepted meanwhile, and a finished matrix waits in its final
// step until the register is free.
// Reset: counts return to 2 x 2, the matrix position returns to the first entry,
// no result is pending; the stores are not cleared (each entry is written first).
// Depends on psp_pkg, psp_if, psp_cfg, psp_cmp and psp_seq.
module payoff_saddle_point_finder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    psp_in_if.sink                       i_in,
    psp_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psp_pkg::APB_AW-1:0]   paddr,
    input  logic [psp_pkg::APB_DW-1:0]   pwdata,
    output logic [psp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    psp_pkg::t_cfg                     w_cfg;
    psp_pkg::t_cmp                     w_cmp;
    logic signed [psp_pkg::DATA_W-1:0] w_a;
    logic signed [psp_pkg::DATA_W-1:0] w_b;

    psp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    psp_cmp u_cmp (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_cmp)
    );

    psp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_a     (w_a),
        .o_b     (w_b),
        .i_cmp   (w_cmp)
    );

endmodule
